// ----- sv/b64_pkg.sv -----
package b64_pkg;

    // characters per output line before a line feed
    localparam logic [6:0] LINE_CHARS = 7'd72;
    localparam logic [6:0] GROUP_CHARS = 7'd4;

    // special characters
    localparam logic [7:0] CHAR_LF  = 8'h0A;
    localparam logic [7:0] CHAR_NUL = 8'h00;
    localparam logic [7:0] CHAR_PAD = 8'h3D;

    // input op codes
    localparam logic OP_DATA  = 1'b0;
    localparam logic OP_FLUSH = 1'b1;

    // command queue between front and back
    localparam int QDEPTH = 4;
    localparam int QAW    = $clog2(QDEPTH);

    // maximum characters in one command
    localparam int CMD_CHARS = 6;
    localparam int CMD_LENW  = $clog2(CMD_CHARS + 1);

    // one request from the front: a short run of characters
    typedef struct packed {
        logic [CMD_CHARS-1:0][7:0] chars;
        logic [CMD_LENW-1:0]       len;
        logic                      term;
    } t_b64_cmd;

    // six-bit value to base64 character
    function automatic logic [7:0] b64_sym(input logic [5:0] v);
        logic [7:0] w;
        w = {2'b00, v};
        case (v) inside
            [6'd0:6'd25]:  return 8'h41 + w;
            [6'd26:6'd51]: return 8'h61 + w - 8'd26;
            [6'd52:6'd61]: return 8'h30 + w - 8'd52;
            6'd62:         return 8'h2B;
            default:       return 8'h2F;
        endcase
    endfunction

endpackage

// ----- sv/b64_if.sv -----
interface b64_in_if;
    logic       valid;
    logic       ready;
    logic       op;
    logic [7:0] data_byte;

    modport source (output valid, output op, output data_byte, input ready);
    modport sink   (input valid, input op, input data_byte, output ready);
endinterface

interface b64_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_char;
    logic       is_last;

    modport source (output valid, output out_char, output is_last, input ready);
    modport sink   (input valid, input out_char, input is_last, output ready);
endinterface

// ----- sv/b64_front.sv -----
module b64_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  logic              i_op,
    input  logic [7:0]        i_data_byte,
    input  logic              i_q_not_full,
    output logic              o_ready,
    output logic              o_push,
    output b64_pkg::t_b64_cmd o_cmd
);

    logic [15:0] r_held, n_held;
    logic [1:0]  r_fill, n_fill;
    logic [6:0]  r_line, n_line;

    logic              accept;
    logic [7:0]        b0_pair;
    logic [7:0]        b1_pair;
    logic [7:0]        b0_single;
    logic [6:0]        line_sum;
    logic              lf_data;
    logic              lf_flush;
    b64_pkg::t_b64_cmd cmd;
    logic              push;

    assign o_ready  = i_q_not_full;
    assign accept   = i_valid & i_q_not_full;
    assign b0_pair  = r_held[15:8];
    assign b1_pair  = r_held[7:0];
    assign b0_single = r_held[7:0];
    assign line_sum = r_line + b64_pkg::GROUP_CHARS;
    assign lf_data  = (line_sum >= b64_pkg::LINE_CHARS);

    // classify the request and build the character run
    always_comb begin
        n_held   = r_held;
        n_fill   = r_fill;
        n_line   = r_line;
        push     = 1'b0;
        lf_flush = 1'b0;
        cmd      = '0;
        if (accept) begin
            if (i_op == b64_pkg::OP_DATA) begin
                if (r_fill < 2'd2) begin
                    n_held = {r_held[7:0], i_data_byte};
                    n_fill = r_fill + 2'd1;
                end else begin
                    // third byte closes a group
                    push          = 1'b1;
                    cmd.chars[0]  = b64_pkg::b64_sym(b0_pair[7:2]);
                    cmd.chars[1]  = b64_pkg::b64_sym({b0_pair[1:0], b1_pair[7:4]});
                    cmd.chars[2]  = b64_pkg::b64_sym({b1_pair[3:0], i_data_byte[7:6]});
                    cmd.chars[3]  = b64_pkg::b64_sym(i_data_byte[5:0]);
                    cmd.chars[4]  = b64_pkg::CHAR_LF;
                    cmd.len       = lf_data ? b64_pkg::CMD_LENW'(5) : b64_pkg::CMD_LENW'(4);
                    cmd.term      = 1'b0;
                    n_held        = '0;
                    n_fill        = 2'd0;
                    n_line        = lf_data ? 7'd0 : line_sum;
                end
            end else begin
                // end of message: remainder, optional line feed, terminator
                push     = 1'b1;
                cmd.term = 1'b1;
                case (r_fill)
                    2'd0: begin
                        lf_flush     = (r_line != 7'd0);
                        cmd.chars[0] = lf_flush ? b64_pkg::CHAR_LF : b64_pkg::CHAR_NUL;
                        cmd.chars[1] = b64_pkg::CHAR_NUL;
                        cmd.len      = lf_flush ? b64_pkg::CMD_LENW'(2)
                                                : b64_pkg::CMD_LENW'(1);
                    end
                    2'd1: begin
                        lf_flush     = (line_sum != 7'd0);
                        cmd.chars[0] = b64_pkg::b64_sym(b0_single[7:2]);
                        cmd.chars[1] = b64_pkg::b64_sym({b0_single[1:0], 4'b0000});
                        cmd.chars[2] = b64_pkg::CHAR_PAD;
                        cmd.chars[3] = b64_pkg::CHAR_PAD;
                        cmd.chars[4] = lf_flush ? b64_pkg::CHAR_LF : b64_pkg::CHAR_NUL;
                        cmd.chars[5] = b64_pkg::CHAR_NUL;
                        cmd.len      = lf_flush ? b64_pkg::CMD_LENW'(6)
                                                : b64_pkg::CMD_LENW'(5);
                    end
                    default: begin
                        lf_flush     = (line_sum != 7'd0);
                        cmd.chars[0] = b64_pkg::b64_sym(b0_pair[7:2]);
                        cmd.chars[1] = b64_pkg::b64_sym({b0_pair[1:0], b1_pair[7:4]});
                        cmd.chars[2] = b64_pkg::b64_sym({b1_pair[3:0], 2'b00});
                        cmd.chars[3] = b64_pkg::CHAR_PAD;
                        cmd.chars[4] = lf_flush ? b64_pkg::CHAR_LF : b64_pkg::CHAR_NUL;
                        cmd.chars[5] = b64_pkg::CHAR_NUL;
                        cmd.len      = lf_flush ? b64_pkg::CMD_LENW'(6)
                                                : b64_pkg::CMD_LENW'(5);
                    end
                endcase
                n_held = '0;
                n_fill = 2'd0;
                n_line = 7'd0;
            end
        end
    end

    assign o_push = push;
    assign o_cmd  = cmd;

    // group and line state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held <= '0;
            r_fill <= 2'd0;
            r_line <= 7'd0;
        end else begin
            r_held <= n_held;
            r_fill <= n_fill;
            r_line <= n_line;
        end
    end

endmodule

// ----- sv/b64_queue.sv -----
module b64_queue (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  b64_pkg::t_b64_cmd i_cmd,
    input  logic              i_pop,
    output logic              o_not_full,
    output logic              o_not_empty,
    output b64_pkg::t_b64_cmd o_cmd
);

    b64_pkg::t_b64_cmd          r_slot [b64_pkg::QDEPTH];
    logic [b64_pkg::QAW-1:0]    r_wr_ptr, n_wr_ptr;
    logic [b64_pkg::QAW-1:0]    r_rd_ptr, n_rd_ptr;
    logic [b64_pkg::QAW:0]      r_count, n_count;
    logic                       do_push;
    logic                       do_pop;

    assign o_not_full  = (r_count != (b64_pkg::QAW+1)'(b64_pkg::QDEPTH));
    assign o_not_empty = (r_count != '0);
    assign o_cmd       = r_slot[r_rd_ptr];
    assign do_push     = i_push & o_not_full;
    assign do_pop      = i_pop & o_not_empty;

    // pointer and occupancy update
    always_comb begin
        n_wr_ptr = do_push ? r_wr_ptr + 1'b1 : r_wr_ptr;
        n_rd_ptr = do_pop ? r_rd_ptr + 1'b1 : r_rd_ptr;
        n_count  = r_count;
        if (do_push && !do_pop) begin
            n_count = r_count + 1'b1;
        end else if (!do_push && do_pop) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // slot storage
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_slot[r_wr_ptr] <= i_cmd;
        end
    end

endmodule

// ----- sv/b64_back.sv -----
module b64_back (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_q_not_empty,
    input  b64_pkg::t_b64_cmd i_q_cmd,
    output logic              o_pop,
    input  logic              i_out_ready,
    output logic              o_out_valid,
    output logic [7:0]        o_out_char,
    output logic              o_out_last
);

    b64_pkg::t_b64_cmd            r_cmd;
    logic                         r_cmd_valid;
    logic [b64_pkg::CMD_LENW-1:0] r_pos;
    logic                         r_out_valid;
    logic [7:0]                   r_out_char;
    logic                         r_out_last;

    logic out_adv;
    logic emit;
    logic at_end;
    logic done;
    logic pop;

    // one character per cycle into the output register while that register is empty or being taken
    assign out_adv = ~r_out_valid | i_out_ready;
    assign emit    = r_cmd_valid & out_adv;
    assign at_end  = (r_pos == r_cmd.len - 1'b1);
    assign done    = emit & at_end;
    assign pop     = i_q_not_empty & (~r_cmd_valid | done);
    assign o_pop   = pop;

    // current request and position in it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cmd_valid <= 1'b0;
            r_pos       <= '0;
        end else if (pop) begin
            r_cmd_valid <= 1'b1;
            r_pos       <= '0;
        end else if (done) begin
            r_cmd_valid <= 1'b0;
        end else if (emit) begin
            r_pos <= r_pos + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (pop) begin
            r_cmd <= i_q_cmd;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (emit) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_out_char <= r_cmd.chars[r_pos];
            r_out_last <= r_cmd.term & at_end;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_char  = r_out_char;
    assign o_out_last  = r_out_last;

endmodule

// ----- sv/base64_stream_encoder_top.sv -----
// input bytes are taken one per cycle while the command queue has room
// output gives one character per cycle while it is taken and requests are queued
// a group's first character passes the queue, request and output registers
// end of message gives one to six characters, the last one is the terminator
// reset (synchronous, active low) clears group, line count, queue and output
module base64_stream_encoder_top (
    input  logic       i_clk,
    input  logic       i_rst_n,
    b64_in_if.sink     i_in,
    b64_out_if.source  o_out
);

    logic              push;
    b64_pkg::t_b64_cmd push_cmd;
    logic              q_not_full;
    logic              q_not_empty;
    b64_pkg::t_b64_cmd q_cmd;
    logic              pop;
    logic              front_ready;

    // front: group assembly and line counting
    b64_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_in.valid),
        .i_op         (i_in.op),
        .i_data_byte  (i_in.data_byte),
        .i_q_not_full (q_not_full),
        .o_ready      (front_ready),
        .o_push       (push),
        .o_cmd        (push_cmd)
    );

    assign i_in.ready = front_ready;

    // request queue
    b64_queue u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .i_cmd       (push_cmd),
        .i_pop       (pop),
        .o_not_full  (q_not_full),
        .o_not_empty (q_not_empty),
        .o_cmd       (q_cmd)
    );

    // back: character sequencing
    b64_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_q_not_empty (q_not_empty),
        .i_q_cmd       (q_cmd),
        .o_pop         (pop),
        .i_out_ready   (o_out.ready),
        .o_out_valid   (o_out.valid),
        .o_out_char    (o_out.out_char),
        .o_out_last    (o_out.is_last)
    );

endmodule

// ----- sv/b64_checker.sv -----
module b64_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_out_valid,
    input logic       i_out_ready,
    input logic [7:0] i_out_char,
    input logic       i_out_last
);

    // a waiting character stays offered
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("output request dropped while stalled");

    // a waiting character does not change
    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> $stable(i_out_char) && $stable(i_out_last))
        else $error("output request changed while stalled");

    // the terminator is a zero byte
    a_last_is_nul: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_last |-> i_out_char == 8'h00)
        else $error("last result is not the terminator");

    // only the terminator carries a zero byte
    a_nul_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_last |-> i_out_char != 8'h00)
        else $error("zero byte before the end of message");

endmodule

bind base64_stream_encoder_top b64_checker u_b64_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_out_char  (o_out.out_char),
    .i_out_last  (o_out.is_last)
);

// ----- verif/tb.sv -----
`timescale 1ns / 100ps

module tb;

    localparam int    CYCLE_LIMIT  = 200000;
    localparam int    DRAIN_CYCLES = 24;
    localparam string B64_ALPHABET =
        "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";

    typedef struct packed {
        logic       op;
        logic [7:0] data;
    } t_b64_item;

    typedef struct packed {
        logic [7:0] ch;
        logic       last;
    } t_b64_char;

    logic i_clk;
    logic i_rst_n;

    b64_in_if  in_bus ();
    b64_out_if out_bus ();

    base64_stream_encoder_top u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_bus),
        .o_out   (out_bus)
    );

    // pending input requests and expected output characters
    t_b64_item byte_reqs_q[$];
    t_b64_char enc_chars_q[$];

    // encoder state mirrored by the predictor
    logic [15:0] grp_bytes;
    logic [1:0]  grp_fill;
    logic [6:0]  line_cnt;

    int        total_reqs;
    int        sent_cnt;
    int        err_cnt;
    int        cycle_cnt;
    logic      steady;
    t_b64_item nxt_req;

    // no idling on either side over a middle stretch of the run
    assign steady = (sent_cnt >= 140) && (sent_cnt < 240);

    // clock
    always begin
        i_clk = 1'b0;
        #6;
        i_clk = 1'b1;
        #6;
    end

    function automatic logic [7:0] b64_char_of(input logic [5:0] v);
        return B64_ALPHABET[int'(v)];
    endfunction

    task automatic push_char(input logic [7:0] ch, input logic last);
        t_b64_char c;
        c.ch   = ch;
        c.last = last;
        enc_chars_q.push_back(c);
    endtask

    // work out the characters caused by one accepted request
    task automatic encode_req(input logic op, input logic [7:0] b);
        logic [7:0] b0;
        logic [7:0] b1;
        b0 = grp_bytes[15:8];
        b1 = grp_bytes[7:0];
        if (op == b64_pkg::OP_DATA) begin
            if (grp_fill < 2'd2) begin
                grp_bytes = {grp_bytes[7:0], b};
                grp_fill  = grp_fill + 2'd1;
            end else begin
                push_char(b64_char_of(b0[7:2]), 1'b0);
                push_char(b64_char_of({b0[1:0], b1[7:4]}), 1'b0);
                push_char(b64_char_of({b1[3:0], b[7:6]}), 1'b0);
                push_char(b64_char_of(b[5:0]), 1'b0);
                grp_bytes = '0;
                grp_fill  = '0;
                line_cnt  = line_cnt + b64_pkg::GROUP_CHARS;
                if (line_cnt >= b64_pkg::LINE_CHARS) begin
                    push_char(b64_pkg::CHAR_LF, 1'b0);
                    line_cnt = '0;
                end
            end
        end else begin
            // remainder of one byte, then of two or more
            if (grp_fill == 2'd1) begin
                push_char(b64_char_of(b1[7:2]), 1'b0);
                push_char(b64_char_of({b1[1:0], 4'b0000}), 1'b0);
                push_char(b64_pkg::CHAR_PAD, 1'b0);
                push_char(b64_pkg::CHAR_PAD, 1'b0);
                line_cnt = line_cnt + b64_pkg::GROUP_CHARS;
            end else if (grp_fill >= 2'd2) begin
                push_char(b64_char_of(b0[7:2]), 1'b0);
                push_char(b64_char_of({b0[1:0], b1[7:4]}), 1'b0);
                push_char(b64_char_of({b1[3:0], 2'b00}), 1'b0);
                push_char(b64_pkg::CHAR_PAD, 1'b0);
                line_cnt = line_cnt + b64_pkg::GROUP_CHARS;
            end
            if (line_cnt != 7'd0)
                push_char(b64_pkg::CHAR_LF, 1'b0);
            push_char(b64_pkg::CHAR_NUL, 1'b1);
            grp_bytes = '0;
            grp_fill  = '0;
            line_cnt  = '0;
        end
    endtask

    task automatic queue_req(input logic op, input logic [7:0] data);
        t_b64_item r;
        r.op   = op;
        r.data = data;
        byte_reqs_q.push_back(r);
        total_reqs++;
    endtask

    // a random byte, leaning now and then on the extremes
    function automatic logic [7:0] rand_byte();
        int sel;
        sel = $urandom_range(0, 9);
        if (sel == 0)
            return 8'h00;
        else if (sel == 1)
            return 8'hFF;
        return 8'($urandom);
    endfunction

    // driver: offers the next pending request, idling at random
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_bus.valid <= 1'b0;
        end else begin
            if (in_bus.valid && in_bus.ready) begin
                encode_req(in_bus.op, in_bus.data_byte);
                sent_cnt <= sent_cnt + 1;
            end
            if (!in_bus.valid || in_bus.ready) begin
                if (byte_reqs_q.size() > 0 && (steady || $urandom_range(0, 99) >= 32)) begin
                    nxt_req = byte_reqs_q.pop_front();
                    in_bus.valid     <= 1'b1;
                    in_bus.op        <= nxt_req.op;
                    in_bus.data_byte <= nxt_req.data;
                end else begin
                    in_bus.valid <= 1'b0;
                end
            end
        end
    end

    // monitor: checks each accepted character against the oldest expected one
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            out_bus.ready <= 1'b0;
        end else begin
            if (out_bus.valid && out_bus.ready) begin
                if (enc_chars_q.size() == 0) begin
                    $display("%0t: unexpected character: actual char %h last %b",
                             $time, out_bus.out_char, out_bus.is_last);
                    err_cnt++;
                end else begin
                    t_b64_char want;
                    want = enc_chars_q.pop_front();
                    if (out_bus.out_char !== want.ch) begin
                        $display("%0t: out_char mismatch: expected %h actual %h",
                                 $time, want.ch, out_bus.out_char);
                        err_cnt++;
                    end
                    if (out_bus.is_last !== want.last) begin
                        $display("%0t: is_last mismatch: expected %b actual %b",
                                 $time, want.last, out_bus.is_last);
                        err_cnt++;
                    end
                end
            end
            out_bus.ready <= steady || ($urandom_range(0, 99) >= 32);
        end
    end

    // run limit
    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt >= CYCLE_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    // stimulus, reset and end of run
    initial begin
        int n;
        int sel;
        i_rst_n           = 1'b0;
        in_bus.valid      = 1'b0;
        in_bus.op         = b64_pkg::OP_DATA;
        in_bus.data_byte  = 8'h00;
        out_bus.ready     = 1'b0;
        grp_bytes         = '0;
        grp_fill          = '0;
        line_cnt          = '0;
        total_reqs        = 0;
        sent_cnt          = 0;
        err_cnt           = 0;
        cycle_cnt         = 0;

        // empty messages, the second right after the first
        queue_req(b64_pkg::OP_FLUSH, 8'h00);
        queue_req(b64_pkg::OP_FLUSH, 8'hFF);
        // one-byte and two-byte remainders at the extremes
        queue_req(b64_pkg::OP_DATA, 8'h00);
        queue_req(b64_pkg::OP_FLUSH, 8'h5A);
        queue_req(b64_pkg::OP_DATA, 8'hFF);
        queue_req(b64_pkg::OP_FLUSH, 8'h00);
        queue_req(b64_pkg::OP_DATA, 8'hFF);
        queue_req(b64_pkg::OP_DATA, 8'hFF);
        queue_req(b64_pkg::OP_FLUSH, 8'hA5);
        // whole groups with no remainder, covering '+' and '/'
        queue_req(b64_pkg::OP_DATA, 8'h00);
        queue_req(b64_pkg::OP_DATA, 8'h00);
        queue_req(b64_pkg::OP_DATA, 8'h00);
        queue_req(b64_pkg::OP_DATA, 8'hFB);
        queue_req(b64_pkg::OP_DATA, 8'hEF);
        queue_req(b64_pkg::OP_DATA, 8'hFF);
        queue_req(b64_pkg::OP_FLUSH, 8'h00);
        // group then two-byte remainder
        queue_req(b64_pkg::OP_DATA, 8'h4D);
        queue_req(b64_pkg::OP_DATA, 8'h61);
        queue_req(b64_pkg::OP_DATA, 8'h6E);
        queue_req(b64_pkg::OP_DATA, 8'h80);
        queue_req(b64_pkg::OP_DATA, 8'h01);
        queue_req(b64_pkg::OP_FLUSH, 8'h3C);

        // random messages: mostly short, some around a full line, a few long
        while (total_reqs < 380) begin
            sel = $urandom_range(0, 99);
            if (sel < 75)
                n = $urandom_range(0, 20);
            else if (sel < 90)
                n = $urandom_range(52, 57);
            else
                n = $urandom_range(58, 120);
            for (int i = 0; i < n; i++)
                queue_req(b64_pkg::OP_DATA, rand_byte());
            queue_req(b64_pkg::OP_FLUSH, 8'($urandom));
        end

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (sent_cnt < total_reqs)
            @(posedge i_clk);
        while (enc_chars_q.size() > 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (err_cnt == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
